// File: rtl/layer_blend_channel_core_assert.svh
// Assertion macros for the layer blend channel core.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef LAYER_BLEND_CHANNEL_CORE_ASSERT_SVH
`define LAYER_BLEND_CHANNEL_CORE_ASSERT_SVH

// property checked on every rising clk edge, off while in reset
`define LBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication form: antecedent overlapping consequent
`define LBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/lbc_pkg.sv
// Package for the layer blend channel core: mode codes, register indexes,
// pipeline types and the divide-by-255 helper. No dependencies.
package lbc_pkg;

  localparam logic [4:0] MODE_OPAQUE       = 5'd0;
  localparam logic [4:0] MODE_ALPHA        = 5'd1;
  localparam logic [4:0] MODE_ADD_ALPHA    = 5'd2;
  localparam logic [4:0] MODE_ADDITIVE     = 5'd3;
  localparam logic [4:0] MODE_SUBTRACT     = 5'd4;
  localparam logic [4:0] MODE_MULTIPLY     = 5'd5;
  localparam logic [4:0] MODE_DODGE        = 5'd6;
  localparam logic [4:0] MODE_LIGHTEN      = 5'd7;
  localparam logic [4:0] MODE_DARKEN       = 5'd8;
  localparam logic [4:0] MODE_SCREEN       = 5'd9;
  localparam logic [4:0] MODE_NORMAL       = 5'd10;
  localparam logic [4:0] MODE_O_ADD        = 5'd11;
  localparam logic [4:0] MODE_O_SUB        = 5'd12;
  localparam logic [4:0] MODE_O_MULTIPLY   = 5'd13;
  localparam logic [4:0] MODE_O_SCREEN     = 5'd14;
  localparam logic [4:0] MODE_OVERLAY      = 5'd15;
  localparam logic [4:0] MODE_HARD_LIGHT   = 5'd16;
  localparam logic [4:0] MODE_COLOR_DODGE  = 5'd17;
  localparam logic [4:0] MODE_COLOR_DODGE5 = 5'd18;
  localparam logic [4:0] MODE_COLOR_BURN   = 5'd19;
  localparam logic [4:0] MODE_O_LIGHTEN    = 5'd20;
  localparam logic [4:0] MODE_O_DARKEN     = 5'd21;
  localparam logic [4:0] MODE_DIFFERENCE   = 5'd22;
  localparam logic [4:0] MODE_DIFFERENCE5  = 5'd23;
  localparam logic [4:0] MODE_EXCLUSION    = 5'd24;

  localparam logic REG_BLEND_MODE = 1'b0;
  localparam logic REG_OPACITY    = 1'b1;

  // reciprocal of 255 scaled by 2^25, exact for y below 132000
  localparam logic [17:0] RECIP255 = 18'd131587;

  // how the last stages form the result
  typedef enum logic [2:0] {
    K_DIRECT,   // x is the result
    K_MIX,      // blend x over d with opacity
    K_QUOT,     // quotient is the result
    K_MIXQ,     // blend quotient over d
    K_MIXINVQ   // blend 255 - quotient over d
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] x;
    logic [7:0] d;
    logic [7:0] o;
    logic       sat;
  } carry_t;

  // floor(y / 255) for y below 132000
  function automatic logic [8:0] div255(input logic [17:0] y);
    logic [35:0] p;
    p = y * RECIP255;
    return p[33:25];
  endfunction

  function automatic logic [7:0] clamp9(input logic [8:0] v);
    return v[8] ? 8'd255 : v[7:0];
  endfunction

endpackage

// File: rtl/layer_blend_channel_core.sv
// Layer blend channel core: one source/destination level pair per beat.
// Depends on lbc_pkg and layer_blend_channel_core_assert.svh.
//
// Usage:
//   Input beats (src_level, dst_level) arrive on in_valid/in_ready; each
//   yields one result_level beat on out_valid/out_ready, in order.
//   blend_mode and opacity are written through cfg_we/cfg_index/cfg_data
//   while the pipe is empty; they take effect for the next accepted beat.
//   Throughput is one beat per cycle while the receiver does not stall:
//   an 8-stage pipeline with valid bits, the shared quotient unit
//   resolving two quotient bits in each of its 4 stages.
//   When the receiver stalls, the whole pipe holds and in_ready drops; no
//   beat is lost or repeated, and bubbles stay where they are.
//   Reset empties the pipe and sets blend_mode to opaque, opacity to 255.
`include "layer_blend_channel_core_assert.svh"

module layer_blend_channel_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] src_level,
  input  logic [7:0] dst_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] result_level
);

  logic [4:0] blend_mode;
  logic [7:0] opacity;
  logic       en;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= lbc_pkg::MODE_OPAQUE;
      opacity    <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        lbc_pkg::REG_BLEND_MODE: blend_mode <= cfg_data[4:0];
        lbc_pkg::REG_OPACITY:    opacity    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: raw products
  logic        v1;
  logic [4:0]  m1;
  logic [7:0]  s1, d1, o1;
  logic [15:0] ds1, scr1, so1, dno1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1   <= blend_mode;
      s1   <= src_level;
      d1   <= dst_level;
      o1   <= opacity;
      ds1  <= dst_level * src_level;
      scr1 <= (8'd255 - dst_level) * (8'd255 - src_level);
      so1  <= src_level * opacity;
      dno1 <= dst_level * (8'd255 - opacity);
    end
  end

  // stage 2: scaled terms, mode decode, divider operands
  lbc_pkg::carry_t c2;
  logic [23:0] rem2;
  logic [15:0] den2;
  logic [8:0]  add9, q_m5, q_scr, q_m2, q_d23, q_exc, q_olo, q_ohi;
  logic [7:0]  add_c, sub8, m5, scr8, ov_d, ov_s, mx, mn, ad;
  logic [15:0] d255, diff23;
  logic [16:0] exc;
  logic [24:0] num, numr;

  always_comb begin
    add9   = {1'b0, d1} + {1'b0, s1};
    add_c  = lbc_pkg::clamp9(add9);
    sub8   = (add9 > 9'd255) ? 8'(add9 - 9'd255) : 8'd0;
    q_m5   = lbc_pkg::div255({2'b0, ds1} + 18'd127);
    m5     = q_m5[7:0];
    q_scr  = lbc_pkg::div255({2'b0, scr1} + 18'd127);
    scr8   = 8'd255 - q_scr[7:0];
    q_m2   = lbc_pkg::div255({2'b0, dno1} + 18'd127);
    d255   = {d1, 8'd0} - {8'd0, d1};
    diff23 = (d255 > so1) ? d255 - so1 : so1 - d255;
    q_d23  = lbc_pkg::div255({2'b0, diff23} + 18'd127);
    exc    = ({add9, 8'd0} - {8'd0, add9}) - {ds1, 1'b0};
    q_exc  = lbc_pkg::div255({1'b0, exc} + 18'd127);
    q_olo  = lbc_pkg::div255({1'b0, ds1, 1'b0} + 18'd127);
    q_ohi  = lbc_pkg::div255({1'b0, scr1, 1'b0} + 18'd127);
    ov_d   = (d1 <= 8'd127) ? lbc_pkg::clamp9(q_olo) : 8'd255 - lbc_pkg::clamp9(q_ohi);
    ov_s   = (s1 <= 8'd127) ? lbc_pkg::clamp9(q_olo) : 8'd255 - lbc_pkg::clamp9(q_ohi);
    mx     = (d1 > s1) ? d1 : s1;
    mn     = (d1 < s1) ? d1 : s1;
    ad     = (d1 > s1) ? d1 - s1 : s1 - d1;

    c2.d   = d1;
    c2.o   = o1;
    c2.kind = lbc_pkg::K_DIRECT;
    c2.x   = d1;
    case (m1)
      lbc_pkg::MODE_OPAQUE:       c2.x = s1;
      lbc_pkg::MODE_ALPHA:        begin c2.kind = lbc_pkg::K_MIX; c2.x = s1; end
      lbc_pkg::MODE_ADD_ALPHA:    c2.x = lbc_pkg::clamp9({1'b0, q_m2[7:0]} + {1'b0, s1});
      lbc_pkg::MODE_ADDITIVE:     c2.x = add_c;
      lbc_pkg::MODE_SUBTRACT:     c2.x = sub8;
      lbc_pkg::MODE_MULTIPLY:     c2.x = m5;
      lbc_pkg::MODE_DODGE:        c2.kind = lbc_pkg::K_QUOT;
      lbc_pkg::MODE_LIGHTEN:      c2.x = mx;
      lbc_pkg::MODE_DARKEN:       c2.x = mn;
      lbc_pkg::MODE_SCREEN:       c2.x = scr8;
      lbc_pkg::MODE_NORMAL:       begin c2.kind = lbc_pkg::K_MIX; c2.x = s1; end
      lbc_pkg::MODE_O_ADD:        begin c2.kind = lbc_pkg::K_MIX; c2.x = add_c; end
      lbc_pkg::MODE_O_SUB:        begin c2.kind = lbc_pkg::K_MIX; c2.x = sub8; end
      lbc_pkg::MODE_O_MULTIPLY:   begin c2.kind = lbc_pkg::K_MIX; c2.x = m5; end
      lbc_pkg::MODE_O_SCREEN:     begin c2.kind = lbc_pkg::K_MIX; c2.x = scr8; end
      lbc_pkg::MODE_OVERLAY:      begin c2.kind = lbc_pkg::K_MIX; c2.x = ov_d; end
      lbc_pkg::MODE_HARD_LIGHT:   begin c2.kind = lbc_pkg::K_MIX; c2.x = ov_s; end
      lbc_pkg::MODE_COLOR_DODGE:  c2.kind = lbc_pkg::K_MIXQ;
      lbc_pkg::MODE_COLOR_DODGE5: c2.kind = lbc_pkg::K_QUOT;
      lbc_pkg::MODE_COLOR_BURN:   c2.kind = lbc_pkg::K_MIXINVQ;
      lbc_pkg::MODE_O_LIGHTEN:    begin c2.kind = lbc_pkg::K_MIX; c2.x = mx; end
      lbc_pkg::MODE_O_DARKEN:     begin c2.kind = lbc_pkg::K_MIX; c2.x = mn; end
      lbc_pkg::MODE_DIFFERENCE:   begin c2.kind = lbc_pkg::K_MIX; c2.x = ad; end
      lbc_pkg::MODE_DIFFERENCE5:  c2.x = lbc_pkg::clamp9(q_d23);
      lbc_pkg::MODE_EXCLUSION:    begin c2.kind = lbc_pkg::K_MIX; c2.x = lbc_pkg::clamp9(q_exc); end
      default: ;
    endcase

    // quotient operands: rounded quotient = floor((n + den/2) / den)
    case (m1)
      lbc_pkg::MODE_COLOR_DODGE5: begin
        num  = 25'(d1) * 25'd65025;
        den2 = 16'd65025 - so1;
      end
      lbc_pkg::MODE_COLOR_BURN: begin
        num  = {9'd0, d255 ^ 16'd0} - {9'd0, d255} + {9'd0, (8'd255 - d1), 8'd0}
               - {17'd0, (8'd255 - d1)};
        den2 = {8'd0, s1};
      end
      default: begin
        num  = {9'd0, d255};
        den2 = {8'd0, 8'd255 - s1};
      end
    endcase
    numr   = num + {10'd0, den2[15:1]};
    c2.sat = (den2 == 16'd0) || (numr >= {1'b0, den2, 8'd0});
    rem2   = numr[23:0];
  end

  // stages 3..6: restoring quotient unit, two bits per stage
  localparam int DSTG = 4;
  logic            vd  [0:DSTG];
  lbc_pkg::carry_t cd  [0:DSTG];
  logic [23:0]     rd  [0:DSTG];
  logic [15:0]     dd  [0:DSTG];
  logic [7:0]      qd  [0:DSTG];
  logic [23:0]     rd_next [1:DSTG];
  logic [7:0]      qd_next [1:DSTG];

  always_ff @(posedge clk) begin
    if (rst) vd[0] <= 1'b0;
    else if (en) vd[0] <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd[0] <= c2;
      rd[0] <= rem2;
      dd[0] <= den2;
      qd[0] <= 8'd0;
    end
  end

  always_comb begin
    logic [23:0] r;
    logic [23:0] dsh;
    logic [7:0]  q;
    for (int k = 0; k < DSTG; k++) begin
      r = rd[k];
      q = qd[k];
      for (int j = 0; j < 2; j++) begin
        dsh = {8'd0, dd[k]} << (7 - 2 * k - j);
        if (r >= dsh) begin
          r = r - dsh;
          q[3'(7 - 2 * k - j)] = 1'b1;
        end
      end
      rd_next[k + 1] = r;
      qd_next[k + 1] = q;
    end
  end

  for (genvar k = 1; k <= DSTG; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) vd[k] <= 1'b0;
      else if (en) vd[k] <= vd[k - 1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cd[k] <= cd[k - 1];
        rd[k] <= rd_next[k];
        dd[k] <= dd[k - 1];
        qd[k] <= qd_next[k];
      end
    end
  end

  // stage 7: pick blend operand, form the weighted sum
  logic        v7, mix7;
  logic [7:0]  dir7;
  logic [16:0] sum7;
  logic [7:0]  qf, xf;
  logic        mixf;

  always_comb begin
    qf   = cd[DSTG].sat ? 8'd255 : qd[DSTG];
    xf   = cd[DSTG].x;
    mixf = 1'b0;
    case (cd[DSTG].kind)
      lbc_pkg::K_DIRECT:  ;
      lbc_pkg::K_MIX:     mixf = 1'b1;
      lbc_pkg::K_QUOT:    xf = qf;
      lbc_pkg::K_MIXQ:    begin xf = qf; mixf = 1'b1; end
      lbc_pkg::K_MIXINVQ: begin xf = 8'd255 - qf; mixf = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= vd[DSTG];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mix7 <= mixf;
      dir7 <= xf;
      sum7 <= 17'(cd[DSTG].d) * 17'(8'd255 - cd[DSTG].o)
              + 17'(xf) * 17'(cd[DSTG].o);
    end
  end

  // stage 8: scale by 1/255, output register
  logic [8:0] q_mix;

  assign q_mix = lbc_pkg::div255({1'b0, sum7} + 18'd127);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v7;
  end

  always_ff @(posedge clk) begin
    if (en) result_level <= mix7 ? lbc_pkg::clamp9(q_mix) : dir7;
  end

  `LBC_ASSERT_IMP(a_div_rem, vd[DSTG] && !cd[DSTG].sat, rd[DSTG] < {8'd0, dd[DSTG]}, "quotient remainder out of range")
  `LBC_ASSERT_IMP(a_mix_sum, v7 && mix7, sum7 <= 17'd65025, "blend sum above full scale")
  `LBC_ASSERT(a_stall_hold, !en |=> $stable(v7) && $stable(vd[0]) && $stable(v1), "pipe moved during stall")

endmodule

// File: sim/layer_blend_channel_checker.sv
// Checker for the layer blend channel core: watches the input and result
// channels, predicts each blended level and compares. Depends on lbc_pkg.
`timescale 1ns / 100ps

module layer_blend_channel_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  src_level,
  input  logic [7:0]  dst_level,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  result_level,
  output int          errors,
  output int          pending
);

  logic [4:0] mode_q;
  logic [7:0] opac_q;
  logic [7:0] expected_levels[$];

  function automatic int unsigned rnd_div(longint unsigned num, longint unsigned den);
    return int'((num + den / 2) / den);
  endfunction

  function automatic int unsigned sat255(int unsigned v);
    return v > 255 ? 255 : v;
  endfunction

  function automatic int unsigned mix_over(int unsigned d, int unsigned x, int unsigned o);
    return sat255(rnd_div(longint'(d) * (255 - o) + longint'(x) * o, 255));
  endfunction

  function automatic int unsigned dodge_lv(int unsigned d, int unsigned s);
    if (s >= 255) return 255;
    return sat255(rnd_div(longint'(d) * 255, 255 - s));
  endfunction

  function automatic int unsigned screen_lv(int unsigned d, int unsigned s);
    return 255 - rnd_div((255 - d) * (255 - s), 255);
  endfunction

  function automatic int unsigned split_lv(int unsigned b, int unsigned d, int unsigned s);
    if (b <= 127) return sat255(rnd_div(2 * d * s, 255));
    return 255 - sat255(rnd_div(2 * (255 - d) * (255 - s), 255));
  endfunction

  function automatic logic [7:0] blend_level(logic [7:0] sv, logic [7:0] dv,
                                             logic [7:0] ov, logic [4:0] m);
    int unsigned s, d, o, t;
    s = sv; d = dv; o = ov;
    case (m)
      lbc_pkg::MODE_OPAQUE:       t = s;
      lbc_pkg::MODE_ALPHA,
      lbc_pkg::MODE_NORMAL:       t = mix_over(d, s, o);
      lbc_pkg::MODE_ADD_ALPHA:    t = sat255(rnd_div(d * (255 - o), 255) + s);
      lbc_pkg::MODE_ADDITIVE:     t = sat255(d + s);
      lbc_pkg::MODE_SUBTRACT:     t = d + s > 255 ? d + s - 255 : 0;
      lbc_pkg::MODE_MULTIPLY:     t = rnd_div(d * s, 255);
      lbc_pkg::MODE_DODGE:        t = dodge_lv(d, s);
      lbc_pkg::MODE_LIGHTEN:      t = d > s ? d : s;
      lbc_pkg::MODE_DARKEN:       t = d < s ? d : s;
      lbc_pkg::MODE_SCREEN:       t = screen_lv(d, s);
      lbc_pkg::MODE_O_ADD:        t = mix_over(d, sat255(d + s), o);
      lbc_pkg::MODE_O_SUB:        t = mix_over(d, d + s > 255 ? d + s - 255 : 0, o);
      lbc_pkg::MODE_O_MULTIPLY:   t = mix_over(d, rnd_div(d * s, 255), o);
      lbc_pkg::MODE_O_SCREEN:     t = mix_over(d, screen_lv(d, s), o);
      lbc_pkg::MODE_OVERLAY:      t = mix_over(d, split_lv(d, d, s), o);
      lbc_pkg::MODE_HARD_LIGHT:   t = mix_over(d, split_lv(s, d, s), o);
      lbc_pkg::MODE_COLOR_DODGE:  t = mix_over(d, dodge_lv(d, s), o);
      lbc_pkg::MODE_COLOR_DODGE5: begin
        t = s * o;
        t = t >= 65025 ? 255 : sat255(rnd_div(longint'(d) * 65025, 65025 - t));
      end
      lbc_pkg::MODE_COLOR_BURN: begin
        t = s == 0 ? 0 : 255 - sat255(rnd_div((255 - d) * 255, s));
        t = mix_over(d, t, o);
      end
      lbc_pkg::MODE_O_LIGHTEN:    t = mix_over(d, d > s ? d : s, o);
      lbc_pkg::MODE_O_DARKEN:     t = mix_over(d, d < s ? d : s, o);
      lbc_pkg::MODE_DIFFERENCE:   t = mix_over(d, d > s ? d - s : s - d, o);
      lbc_pkg::MODE_DIFFERENCE5: begin
        t = d * 255;
        t = sat255(rnd_div(t > s * o ? t - s * o : s * o - t, 255));
      end
      lbc_pkg::MODE_EXCLUSION:
        t = mix_over(d, sat255(rnd_div(255 * (d + s) - 2 * d * s, 255)), o);
      default:                    t = d;
    endcase
    return t[7:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode_q <= lbc_pkg::MODE_OPAQUE;
      opac_q <= 8'd255;
      expected_levels.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lbc_pkg::REG_BLEND_MODE) mode_q <= cfg_data[4:0];
        else opac_q <= cfg_data;
      end
      if (in_valid && in_ready)
        expected_levels.push_back(blend_level(src_level, dst_level, opac_q, mode_q));
      if (out_valid && out_ready) begin
        if (expected_levels.size() == 0) begin
          $display("%0t: unexpected result beat, actual %0d", $time, result_level);
          errors <= errors + 1;
        end else begin
          if (expected_levels[0] !== result_level) begin
            $display("%0t: result_level mismatch, expected %0d actual %0d",
                     $time, expected_levels[0], result_level);
            errors <= errors + 1;
          end
          void'(expected_levels.pop_front());
        end
      end
      pending <= expected_levels.size();
    end
  end

endmodule

// File: sim/layer_blend_channel_core_tb.sv
// Testbench top for the layer blend channel core: drives config writes and
// level pairs under varied idling and receiver stalls; the checker predicts and compares.
`timescale 1ns / 100ps

module layer_blend_channel_core_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = lbc_pkg::REG_BLEND_MODE;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] src_level = '0;
  logic [7:0] dst_level = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] result_level;
  int errors, pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  layer_blend_channel_core uut (.*);

  layer_blend_channel_checker chk (.*);

  // receiver side: stall at random per phase
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // valid stays high after the beat until the next idle cycle or drain
  task automatic send_pair(logic [7:0] s, logic [7:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    src_level <= s;
    dst_level <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(logic [4:0] m, logic [7:0] o);
    drain_pipe();
    write_reg(lbc_pkg::REG_BLEND_MODE, {3'b000, m});
    write_reg(lbc_pkg::REG_OPACITY, o);
  endtask

  // biased toward the level extremes
  function automatic logic [7:0] pick_level();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd127 + 8'($urandom_range(1));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    logic [7:0] o;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: opaque at full opacity
    send_pair(8'd200, 8'd17);
    // directed: each mode with the level extremes and saturating divides
    for (int m = 0; m < 32; m++) begin
      o = (m % 3 == 0) ? 8'd255 : (m % 3 == 1) ? 8'd0 : 8'd128;
      set_mode(m[4:0], o);
      send_pair(8'd0, 8'd0);
      send_pair(8'd255, 8'd255);
      send_pair(8'd255, 8'd77);
      send_pair(8'd0, 8'd200);
      send_pair(8'd127, 8'd128);
    end

    // random phases, each with its own idling pattern
    for (int ph = 0; ph < 64; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      case ($urandom_range(3))
        0: o = 8'd0;
        1: o = 8'd255;
        default: o = 8'($urandom_range(255));
      endcase
      set_mode(ph < 50 ? 5'(ph % 25) : 5'($urandom_range(31)), o);
      for (int i = 0; i < 27; i++) send_pair(pick_level(), pick_level());
    end

    idle_pct = 0;
    stall_pct = 0;
    drain_pipe();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: layer_blend_channel_core.f
+incdir+rtl
rtl/lbc_pkg.sv
rtl/layer_blend_channel_core.sv
sim/layer_blend_channel_checker.sv
sim/layer_blend_channel_core_tb.sv
